// ===== design/ltw_pkg.sv =====
// Package for the log truncation watermark controller.
// Holds the FIFO sizing constants, event codes, register addresses and shared types.
// No dependencies; every other design file refers to it by scoped names.
package ltw_pkg;

  // Free-request FIFO sizing.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Sequence numbers and watermarks.
  localparam int SEQ_W = 64;

  // Watermark table.
  localparam int NUM_MARKS = 5;
  localparam int MARK_IW   = $clog2(NUM_MARKS);
  localparam logic [MARK_IW-1:0] MARK_SYNCER = MARK_IW'(2);
  localparam logic [MARK_IW-1:0] MARK_SCRUB  = MARK_IW'(4);

  // Event codes carried in the input tuser.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
  localparam logic [OP_W-1:0] OP_WDONE  = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OP_W-1:0] OP_START  = 3'd4;

  // Stream payload widths.
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 136;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;
  localparam logic CFG_SEL_SYNCER = 1'b0;
  localparam logic CFG_SEL_SCRUB  = 1'b1;

  // Write request into the FIFO storage.
  typedef struct packed {
    logic               we;
    logic [FIFO_AW-1:0] addr;
    logic [SEQ_W-1:0]   data;
  } ltw_fifo_wr_t;

endpackage

// ===== design/log_truncation_watermark_ctrl_core.sv =====
// Top level of the log truncation watermark controller.
// Depends on ltw_pkg, ltw_cmp (shared comparator) and ltw_fifo (request storage).
//
// One event is handled at a time, and in_tready is low until its result has been
// put in the output register. All comparisons go through one 64-bit comparator,
// used once per cycle by the sequencer. The minimum of the five watermarks is
// rebuilt one entry at a time, and an update then runs the partial-cut check.
// Examining the queue handles each head entry compared in two steps (a registered
// read of the head, then the compare). The result waits in its own register.
// While the output stalls, one more event can be taken and worked on, and it then
// holds in its last step until that register is free. The user is to send
// configuration port writes only while the block is idle; the block itself does
// not enforce this. pready is always high.
module log_truncation_watermark_ctrl_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] seq_number, [64] rescue_mode, [65] write_blocked, [71:66] zero
  input  logic [ltw_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] operation, [5:3] component
  input  logic [ltw_pkg::IN_USER_W-1:0]     in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] cut_issued, [64:1] cut_point, [65] update_rejected, [66] queue_overflow,
  // [130:67] current_minimum, [131] busy_now, [135:132] zero
  output logic [ltw_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ltw_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [ltw_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [ltw_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int WS_W = ltw_pkg::FIFO_AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MIN, S_PART1, S_PART2, S_PROC, S_RD, S_POP, S_DECIDE, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Latched event.
  logic [ltw_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [ltw_pkg::MARK_IW-1:0]   comp_r, comp_nxt;
  logic [ltw_pkg::SEQ_W-1:0]     seq_r, seq_nxt;
  logic                          rescue_r, rescue_nxt;
  logic                          blk_r, blk_nxt;

  // Controller state.
  logic [ltw_pkg::SEQ_W-1:0]     marks_r [ltw_pkg::NUM_MARKS];
  logic [ltw_pkg::SEQ_W-1:0]     marks_nxt [ltw_pkg::NUM_MARKS];
  logic [ltw_pkg::SEQ_W-1:0]     min_r, min_nxt;
  logic [ltw_pkg::SEQ_W-1:0]     prev_r, prev_nxt;
  logic [ltw_pkg::SEQ_W-1:0]     last_r, last_nxt;
  logic [ltw_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [ltw_pkg::FIFO_AW-1:0]   head_r, head_nxt;
  logic                          busy_r, busy_nxt;
  logic                          partial_r, partial_nxt;
  logic [ltw_pkg::MARK_IW-1:0]   idx_r, idx_nxt;
  logic                          gt_prev_r, gt_prev_nxt;
  logic                          sat_r, sat_nxt;

  // Result being built and the output register.
  logic                          cut_r, cut_nxt;
  logic [ltw_pkg::SEQ_W-1:0]     cut_pt_r, cut_pt_nxt;
  logic                          rej_r, rej_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ltw_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Configuration registers.
  logic [ltw_pkg::SEQ_W-1:0]     syncer_cfg_r;
  logic [ltw_pkg::SEQ_W-1:0]     scrub_cfg_r;

  // Shared comparator operands and FIFO access.
  logic [ltw_pkg::SEQ_W-1:0]     cmp_a, cmp_b;
  logic                          cmp_lt;
  logic [ltw_pkg::MARK_IW-1:0]   rd_idx;
  logic [ltw_pkg::SEQ_W-1:0]     mark_rd;
  ltw_pkg::ltw_fifo_wr_t         fifo_wr;
  logic [ltw_pkg::SEQ_W-1:0]     fifo_rdata;
  logic [WS_W-1:0]               tail_sum;
  logic [ltw_pkg::FIFO_AW-1:0]   tail_addr;
  logic [ltw_pkg::FIFO_AW-1:0]   head_inc;

  ltw_cmp u_cmp (
    .op_a   (cmp_a),
    .op_b   (cmp_b),
    .a_lt_b (cmp_lt)
  );

  ltw_fifo u_fifo (
    .clk   (clk),
    .wr    (fifo_wr),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  // Configuration port: registers decoded on address bit 3, 64-bit data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syncer_cfg_r <= '0;
      scrub_cfg_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[3] == ltw_pkg::CFG_SEL_SYNCER) begin
        syncer_cfg_r <= cfg_pwdata;
      end else begin
        scrub_cfg_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == ltw_pkg::CFG_SEL_SCRUB) ? scrub_cfg_r : syncer_cfg_r;
  assign cfg_pready = 1'b1;

  // Watermark read port: the event's component during execution, else the scan index.
  assign rd_idx  = (state_r == S_EXEC) ? comp_r : idx_r;
  assign mark_rd = (32'(rd_idx) < ltw_pkg::NUM_MARKS) ? marks_r[rd_idx] : '0;

  // FIFO tail address and head advance, both wrapping at the depth.
  always_comb begin
    tail_sum = WS_W'(head_r) + WS_W'(count_r[ltw_pkg::FIFO_AW-1:0]);
    if (tail_sum >= WS_W'(ltw_pkg::FIFO_DEPTH)) begin
      tail_sum = tail_sum - WS_W'(ltw_pkg::FIFO_DEPTH);
    end
    tail_addr = tail_sum[ltw_pkg::FIFO_AW-1:0];
    head_inc  = (32'(head_r) == ltw_pkg::FIFO_DEPTH - 1) ? '0
              : head_r + ltw_pkg::FIFO_AW'(1);
  end

  // Comparator operand selection per sequencer step.
  always_comb begin
    unique case (state_r)
      S_EXEC: begin
        cmp_a = seq_r;
        cmp_b = mark_rd;
      end
      S_MIN: begin
        cmp_a = mark_rd;
        cmp_b = min_r;
      end
      S_PART1: begin
        cmp_a = prev_r;
        cmp_b = min_r;
      end
      S_POP: begin
        cmp_a = fifo_rdata;
        cmp_b = min_r;
      end
      default: begin
        cmp_a = last_r;
        cmp_b = min_r;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    comp_nxt      = comp_r;
    seq_nxt       = seq_r;
    rescue_nxt    = rescue_r;
    blk_nxt       = blk_r;
    marks_nxt     = marks_r;
    min_nxt       = min_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    busy_nxt      = busy_r;
    partial_nxt   = partial_r;
    idx_nxt       = idx_r;
    gt_prev_nxt   = gt_prev_r;
    sat_nxt       = sat_r;
    cut_nxt       = cut_r;
    cut_pt_nxt    = cut_pt_r;
    rej_nxt       = rej_r;
    ovf_nxt       = ovf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    fifo_wr       = '{we: 1'b0, addr: tail_addr, data: seq_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser[2:0];
          comp_nxt   = in_tuser[5:3];
          seq_nxt    = in_tdata[63:0];
          rescue_nxt = in_tdata[64];
          blk_nxt    = in_tdata[65];
          prev_nxt   = min_r;
          idx_nxt    = '0;
          sat_nxt    = 1'b0;
          cut_nxt    = 1'b0;
          cut_pt_nxt = '0;
          rej_nxt    = 1'b0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      // Apply the event itself.
      S_EXEC: begin
        unique case (op_r)
          ltw_pkg::OP_UPDATE: begin
            if (32'(comp_r) < ltw_pkg::NUM_MARKS) begin
              if (cmp_lt) begin
                rej_nxt = 1'b1;
              end else begin
                marks_nxt[comp_r] = seq_r;
              end
            end
            state_nxt = S_MIN;
          end
          ltw_pkg::OP_PUSH: begin
            if (count_r == ltw_pkg::CNT_W'(ltw_pkg::FIFO_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              fifo_wr.we = 1'b1;
              count_nxt  = count_r + ltw_pkg::CNT_W'(1);
            end
            state_nxt = S_PROC;
          end
          ltw_pkg::OP_WDONE: begin
            busy_nxt  = 1'b0;
            state_nxt = S_PROC;
          end
          ltw_pkg::OP_TICK: begin
            state_nxt = S_PROC;
          end
          ltw_pkg::OP_START: begin
            marks_nxt[ltw_pkg::MARK_SYNCER] = syncer_cfg_r;
            marks_nxt[ltw_pkg::MARK_SCRUB]  = scrub_cfg_r;
            state_nxt = S_MIN;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Rebuild the minimum watermark, one entry per cycle.
      S_MIN: begin
        if (idx_r == '0 || cmp_lt) begin
          min_nxt = mark_rd;
        end
        if (32'(idx_r) == ltw_pkg::NUM_MARKS - 1) begin
          idx_nxt   = '0;
          state_nxt = (op_r == ltw_pkg::OP_UPDATE) ? S_PART1 : S_PROC;
        end else begin
          idx_nxt = idx_r + ltw_pkg::MARK_IW'(1);
        end
      end

      // Did the update raise the minimum?
      S_PART1: begin
        gt_prev_nxt = cmp_lt;
        state_nxt   = S_PART2;
      end

      // Mark a partial cut when the rise also passes the last cut point.
      S_PART2: begin
        if (rescue_r && count_r != '0 && gt_prev_r && cmp_lt) begin
          partial_nxt = 1'b1;
        end
        state_nxt = S_PROC;
      end

      // Decide whether the queue is examined at all.
      S_PROC: begin
        if (busy_r) begin
          state_nxt = S_DONE;
        end else if (rescue_r) begin
          if (count_r == '0) begin
            partial_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end else if (count_r == '0 || blk_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end

      // Head entry is read into the storage's output register.
      S_RD: begin
        state_nxt = S_POP;
      end

      // Pop the head while it lies below the minimum.
      S_POP: begin
        if (cmp_lt) begin
          head_nxt  = head_inc;
          count_nxt = count_r - ltw_pkg::CNT_W'(1);
          sat_nxt   = 1'b1;
          state_nxt = (count_r == ltw_pkg::CNT_W'(1)) ? S_DECIDE : S_RD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      // Issue a cut at the minimum when the mode's conditions hold.
      S_DECIDE: begin
        if (rescue_r) begin
          if (cmp_lt && (sat_r || (partial_r && count_r != '0))) begin
            partial_nxt = 1'b0;
            busy_nxt    = 1'b1;
            last_nxt    = min_r;
            cut_nxt     = 1'b1;
            cut_pt_nxt  = min_r;
          end
        end else if (sat_r) begin
          busy_nxt   = 1'b1;
          last_nxt   = min_r;
          cut_nxt    = 1'b1;
          cut_pt_nxt = min_r;
        end
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {4'b0000, busy_r, min_r, ovf_r, rej_r, cut_pt_r, cut_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < ltw_pkg::NUM_MARKS; i++) begin
        marks_r[i] <= '0;
      end
      min_r       <= '0;
      last_r      <= '0;
      count_r     <= '0;
      head_r      <= '0;
      busy_r      <= 1'b0;
      partial_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      marks_r     <= marks_nxt;
      min_r       <= min_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      busy_r      <= busy_nxt;
      partial_r   <= partial_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    comp_r     <= comp_nxt;
    seq_r      <= seq_nxt;
    rescue_r   <= rescue_nxt;
    blk_r      <= blk_nxt;
    prev_r     <= prev_nxt;
    gt_prev_r  <= gt_prev_nxt;
    sat_r      <= sat_nxt;
    cut_r      <= cut_nxt;
    cut_pt_r   <= cut_pt_nxt;
    rej_r      <= rej_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/ltw_cmp.sv =====
// Shared 64-bit magnitude comparator of the watermark controller.
// Depends on ltw_pkg for the sequence number width.
module ltw_cmp (
  input  logic [ltw_pkg::SEQ_W-1:0] op_a,
  input  logic [ltw_pkg::SEQ_W-1:0] op_b,
  output logic                      a_lt_b
);

  // Unsigned less-than; the sequencer picks the operands every cycle.
  assign a_lt_b = (op_a < op_b);

endmodule

// ===== design/ltw_fifo.sv =====
// Storage of the free-request FIFO: one write port and one registered read port.
// Depends on ltw_pkg for the depth, address width and write request type.
module ltw_fifo (
  input  logic                          clk,
  input  ltw_pkg::ltw_fifo_wr_t         wr,
  input  logic [ltw_pkg::FIFO_AW-1:0]   raddr,
  output logic [ltw_pkg::SEQ_W-1:0]     rdata
);

  logic [ltw_pkg::SEQ_W-1:0] mem [ltw_pkg::FIFO_DEPTH];
  logic [ltw_pkg::SEQ_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read of the queue head.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ltw_checker.sv =====
// Port-level checks for the log truncation watermark controller, bound to the top level.
// Depends on ltw_pkg for port widths and on log_truncation_watermark_ctrl_core.
module ltw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ltw_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A stalled result keeps its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input ready is low in the cycle after an accepted event.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // A cut leaves a write outstanding.
  a_cut_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[131])
    else $error("cut issued without busy");

  // A cut is placed at the minimum watermark.
  a_cut_at_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[64:1] == out_tdata[130:67])
    else $error("cut point differs from minimum");

  // Without a cut the cut point reads zero.
  a_no_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[64:1] == '0)
    else $error("cut point set without a cut");

endmodule

bind log_truncation_watermark_ctrl_core ltw_checker u_ltw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/log_truncation_watermark_ctrl_core_test.sv =====
// Self-checking testbench for the log truncation watermark controller.
// Depends on ltw_pkg and log_truncation_watermark_ctrl_core; it predicts every result
// transfer and compares it field by field while the stream sides idle at random in some phases.
module log_truncation_watermark_ctrl_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 800000;
  // Operations and components are 3-bit codes.
  localparam int CODE_SPAN = 1 << ltw_pkg::OP_W;
  localparam logic [ltw_pkg::MARK_IW-1:0] MARK_HULL    = ltw_pkg::MARK_IW'(0);
  localparam logic [ltw_pkg::MARK_IW-1:0] MARK_SYNCLOG = ltw_pkg::MARK_IW'(1);
  localparam logic [ltw_pkg::MARK_IW-1:0] MARK_HUGE    = ltw_pkg::MARK_IW'(3);
  localparam logic [ltw_pkg::CFG_AW-1:0] ADDR_SYNCER_MARK = ltw_pkg::CFG_AW'(0);
  localparam logic [ltw_pkg::CFG_AW-1:0] ADDR_SCRUB_MARK  = ltw_pkg::CFG_AW'(8);
  localparam logic [ltw_pkg::SEQ_W-1:0] SEQ_ALL_ONES = '1;

  typedef struct packed {
    logic [ltw_pkg::OP_W-1:0]    op;
    logic [ltw_pkg::MARK_IW-1:0] comp;
    logic [ltw_pkg::SEQ_W-1:0]   seq;
    logic                        rescue;
    logic                        blocked;
  } wm_event_t;

  // Same bit order as out_tdata[131:0].
  typedef struct packed {
    logic                      busy;
    logic [ltw_pkg::SEQ_W-1:0] minimum;
    logic                      overflow;
    logic                      rejected;
    logic [ltw_pkg::SEQ_W-1:0] point;
    logic                      cut;
  } cut_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ltw_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [ltw_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ltw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [ltw_pkg::CFG_AW-1:0]     cfg_paddr = '0;
  logic [ltw_pkg::CFG_DW-1:0]     cfg_pwdata = '0;
  logic [ltw_pkg::CFG_DW-1:0]     cfg_prdata;
  logic                           cfg_pready;

  log_truncation_watermark_ctrl_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // Predicted state of the controller.
  logic [ltw_pkg::SEQ_W-1:0] mark_tab [ltw_pkg::NUM_MARKS];
  logic [ltw_pkg::SEQ_W-1:0] free_req [ltw_pkg::FIFO_DEPTH];
  int unsigned               req_count;
  int unsigned               req_head;
  bit                        cut_busy;
  bit                        partial_cut;
  logic [ltw_pkg::SEQ_W-1:0] last_cut;
  logic [ltw_pkg::SEQ_W-1:0] syncer_cfg;
  logic [ltw_pkg::SEQ_W-1:0] scrub_cfg;

  cut_result_t expected_cuts[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  function automatic logic [ltw_pkg::SEQ_W-1:0] lowest_mark();
    logic [ltw_pkg::SEQ_W-1:0] m;
    m = mark_tab[0];
    for (int i = 1; i < ltw_pkg::NUM_MARKS; i++)
      if (mark_tab[i] < m) m = mark_tab[i];
    return m;
  endfunction

  // Drops every queued request at the front that lies below the limit.
  function automatic bit pop_satisfied(input logic [ltw_pkg::SEQ_W-1:0] lim);
    bit any;
    any = 1'b0;
    while (req_count > 0 && free_req[req_head] < lim) begin
      req_head = (req_head + 1) % ltw_pkg::FIFO_DEPTH;
      req_count--;
      any = 1'b1;
    end
    return any;
  endfunction

  // Pops satisfied requests and decides whether a cut goes out.
  function automatic void settle_cut(input wm_event_t ev, inout cut_result_t r);
    logic [ltw_pkg::SEQ_W-1:0] lim;
    bit                        popped;
    bit                        partial_live;
    if (cut_busy) return;
    lim = lowest_mark();
    if (ev.rescue) begin
      if (req_count == 0) begin
        partial_cut = 1'b0;
        return;
      end
      popped = pop_satisfied(lim);
      partial_live = partial_cut && req_count > 0;
      if (lim <= last_cut || (!popped && !partial_live)) return;
      partial_cut = 1'b0;
    end else begin
      if (req_count == 0 || free_req[req_head] >= lim) return;
      if (ev.blocked) return;
      if (!pop_satisfied(lim)) return;
    end
    cut_busy = 1'b1;
    last_cut = lim;
    r.cut = 1'b1;
    r.point = lim;
  endfunction

  function automatic cut_result_t predict_cut(input wm_event_t ev);
    cut_result_t               r;
    logic [ltw_pkg::SEQ_W-1:0] was_low;
    logic [ltw_pkg::SEQ_W-1:0] now_low;
    r = '0;
    case (ev.op)
      ltw_pkg::OP_UPDATE: begin
        was_low = lowest_mark();
        if (ev.comp < ltw_pkg::NUM_MARKS) begin
          if (ev.seq < mark_tab[ev.comp]) r.rejected = 1'b1;
          else mark_tab[ev.comp] = ev.seq;
        end
        now_low = lowest_mark();
        if (ev.rescue && req_count > 0 && now_low > was_low && now_low > last_cut)
          partial_cut = 1'b1;
        settle_cut(ev, r);
      end
      ltw_pkg::OP_PUSH: begin
        if (req_count >= ltw_pkg::FIFO_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          free_req[(req_head + req_count) % ltw_pkg::FIFO_DEPTH] = ev.seq;
          req_count++;
        end
        settle_cut(ev, r);
      end
      ltw_pkg::OP_WDONE: begin
        cut_busy = 1'b0;
        settle_cut(ev, r);
      end
      ltw_pkg::OP_TICK: settle_cut(ev, r);
      ltw_pkg::OP_START: begin
        mark_tab[ltw_pkg::MARK_SYNCER] = syncer_cfg;
        mark_tab[ltw_pkg::MARK_SCRUB] = scrub_cfg;
        settle_cut(ev, r);
      end
      default: ;
    endcase
    r.minimum = lowest_mark();
    r.busy = cut_busy;
    return r;
  endfunction

  // Mostly forward updates and pushes near the current minimum, with some noise.
  function automatic wm_event_t random_event(input int rescue_pct);
    wm_event_t                 ev;
    int                        pick;
    logic [ltw_pkg::SEQ_W-1:0] low;
    logic [ltw_pkg::SEQ_W-1:0] step;
    pick = $urandom_range(99);
    low = lowest_mark();
    ev.op = ltw_pkg::OP_TICK;
    ev.comp = ltw_pkg::MARK_IW'($urandom_range(0, ltw_pkg::NUM_MARKS - 1));
    ev.seq = {$urandom, $urandom};
    ev.rescue = $urandom_range(99) < rescue_pct;
    ev.blocked = $urandom_range(99) < 25;
    if (pick < 40) begin
      ev.op = ltw_pkg::OP_UPDATE;
      step = ltw_pkg::SEQ_W'($urandom_range(0, 300));
      case ($urandom_range(19))
        0: ;
        1: ev.comp = ltw_pkg::MARK_IW'($urandom_range(ltw_pkg::NUM_MARKS, CODE_SPAN - 1));
        2: ev.seq = (mark_tab[ev.comp] > step) ? mark_tab[ev.comp] - step - 1 : '0;
        default: begin
          ev.seq = mark_tab[ev.comp] + step;
          if (ev.seq < mark_tab[ev.comp]) ev.seq = SEQ_ALL_ONES;
        end
      endcase
    end else if (pick < 68) begin
      ev.op = ltw_pkg::OP_PUSH;
      step = ltw_pkg::SEQ_W'($urandom_range(0, 400));
      if ($urandom_range(99) < 60) begin
        ev.seq = (low > step) ? low - step : '0;
      end else begin
        ev.seq = low + step;
        if (ev.seq < low) ev.seq = SEQ_ALL_ONES;
      end
    end else if (pick < 82) begin
      ev.op = ltw_pkg::OP_WDONE;
    end else if (pick < 90) begin
      ev.op = ltw_pkg::OP_TICK;
    end else if (pick < 95) begin
      ev.op = ltw_pkg::OP_START;
    end else begin
      ev.op = ltw_pkg::OP_W'($urandom_range(ltw_pkg::OP_START + 1, CODE_SPAN - 1));
    end
    return ev;
  endfunction

  // Offers one event and records its expected result once the transfer completes.
  task automatic send_event(input logic [ltw_pkg::OP_W-1:0] op,
                            input logic [ltw_pkg::MARK_IW-1:0] comp,
                            input logic [ltw_pkg::SEQ_W-1:0] seq, input logic rescue = 1'b0,
                            input logic blocked = 1'b0);
    wm_event_t ev;
    ev = '{op: op, comp: comp, seq: seq, rescue: rescue, blocked: blocked};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {comp, op};
    in_tdata <= {{(ltw_pkg::IN_DATA_W - ltw_pkg::SEQ_W - 2){1'b0}}, blocked, rescue, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_cuts.insert(expected_cuts.size(), predict_cut(ev));
  endtask

  task automatic write_register(input logic [ltw_pkg::CFG_AW-1:0] addr,
                                input logic [ltw_pkg::SEQ_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_SYNCER_MARK) syncer_cfg = value;
    else scrub_cfg = value;
    @(posedge clk);
  endtask

  // Lets every outstanding result arrive before touching the registers.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (expected_cuts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_watermark_updates();
    send_event(ltw_pkg::OP_TICK, MARK_HULL, '0);
    send_event(ltw_pkg::OP_START, MARK_HULL, '0);
    send_event(ltw_pkg::OP_UPDATE, MARK_HULL, 64'd10);
    send_event(ltw_pkg::OP_UPDATE, MARK_SYNCLOG, 64'd20);
    send_event(ltw_pkg::OP_UPDATE, MARK_HUGE, 64'd30);
    // Moving a watermark backwards, then an owner that does not exist.
    send_event(ltw_pkg::OP_UPDATE, MARK_HULL, 64'd5);
    send_event(ltw_pkg::OP_UPDATE, ltw_pkg::MARK_IW'(CODE_SPAN - 1), SEQ_ALL_ONES);
  endtask

  task automatic test_free_queue();
    send_event(ltw_pkg::OP_PUSH, MARK_HULL, 64'd3);
    send_event(ltw_pkg::OP_PUSH, MARK_HULL, 64'd4);
    send_event(ltw_pkg::OP_WDONE, MARK_HULL, '0);
    send_event(ltw_pkg::OP_WDONE, MARK_HULL, '0, 1'b0, 1'b1);
    // Fill the queue past its depth so the last push is dropped.
    for (int i = 0; i <= ltw_pkg::FIFO_DEPTH; i++)
      send_event(ltw_pkg::OP_PUSH, MARK_HULL, 64'd200 + i, 1'b0, i[0]);
  endtask

  task automatic test_rescue_cuts();
    send_event(ltw_pkg::OP_UPDATE, MARK_HULL, 64'd100, 1'b1, 1'b0);
    send_event(ltw_pkg::OP_WDONE, MARK_HULL, '0, 1'b1, 1'b0);
    send_event(ltw_pkg::OP_UPDATE, MARK_SYNCLOG, 64'd300, 1'b1, 1'b0);
    send_event(ltw_pkg::OP_WDONE, MARK_HULL, '0);
    send_event(ltw_pkg::OP_UPDATE, ltw_pkg::MARK_SYNCER, 64'd300, 1'b0, 1'b1);
    send_event(ltw_pkg::OP_UPDATE, ltw_pkg::MARK_SCRUB, 64'd300);
    send_event(ltw_pkg::OP_UPDATE, MARK_HUGE, 64'd300);
    // Raising the last low watermark releases the whole queue at once.
    send_event(ltw_pkg::OP_UPDATE, MARK_HULL, 64'd300);
    send_event(ltw_pkg::OP_WDONE, MARK_HULL, '0, 1'b1, 1'b0);
  endtask

  task automatic test_extremes();
    send_event(ltw_pkg::OP_UPDATE, ltw_pkg::MARK_SCRUB, SEQ_ALL_ONES);
    send_event(ltw_pkg::OP_TICK, MARK_HULL, SEQ_ALL_ONES, 1'b1, 1'b1);
    for (int op = ltw_pkg::OP_START + 1; op < CODE_SPAN; op++)
      send_event(ltw_pkg::OP_W'(op), ltw_pkg::MARK_IW'(op), {$urandom, $urandom});
    send_event(ltw_pkg::OP_UPDATE, MARK_HULL, '0);
    // Syncer disabled: its start mark is all ones.
    wait_quiet();
    write_register(ADDR_SYNCER_MARK, SEQ_ALL_ONES);
    write_register(ADDR_SCRUB_MARK, '0);
    send_event(ltw_pkg::OP_START, MARK_HULL, '0);
  endtask

  task automatic test_random_traffic(input int count, input int rescue_pct,
                                     input logic [ltw_pkg::SEQ_W-1:0] syncer_mark,
                                     input logic [ltw_pkg::SEQ_W-1:0] scrub_mark);
    wm_event_t ev;
    wait_quiet();
    write_register(ADDR_SYNCER_MARK, syncer_mark);
    write_register(ADDR_SCRUB_MARK, scrub_mark);
    repeat (count) begin
      ev = random_event(rescue_pct);
      send_event(ev.op, ev.comp, ev.seq, ev.rescue, ev.blocked);
    end
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    wm_event_t ev;
    wait_quiet();
    hold_request = 400;
    repeat (12) begin
      ev = random_event(20);
      send_event(ev.op, ev.comp, ev.seq, ev.rescue, ev.blocked);
    end
  endtask

  // Result receiver with random stalls and an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  function automatic void check_field(input string name,
                                      input logic [ltw_pkg::SEQ_W-1:0] want,
                                      input logic [ltw_pkg::SEQ_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    cut_result_t got;
    cut_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(cut_result_t)-1:0];
      if (expected_cuts.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_cuts[0];
        expected_cuts.delete(0);
        check_field("cut_issued", ltw_pkg::SEQ_W'(want.cut), ltw_pkg::SEQ_W'(got.cut));
        check_field("cut_point", want.point, got.point);
        check_field("update_rejected", ltw_pkg::SEQ_W'(want.rejected),
                    ltw_pkg::SEQ_W'(got.rejected));
        check_field("queue_overflow", ltw_pkg::SEQ_W'(want.overflow),
                    ltw_pkg::SEQ_W'(got.overflow));
        check_field("current_minimum", want.minimum, got.minimum);
        check_field("busy_now", ltw_pkg::SEQ_W'(want.busy), ltw_pkg::SEQ_W'(got.busy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (mark_tab[i]) mark_tab[i] = '0;
    foreach (free_req[i]) free_req[i] = '0;
    req_count = 0;
    req_head = 0;
    cut_busy = 1'b0;
    partial_cut = 1'b0;
    last_cut = '0;
    syncer_cfg = '0;
    scrub_cfg = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 73;
    write_register(ADDR_SYNCER_MARK, 64'd40);
    write_register(ADDR_SCRUB_MARK, 64'd50);
    test_watermark_updates();
    test_free_queue();
    test_rescue_cuts();
    test_extremes();
    test_random_traffic(580, 30, '0, '0);

    send_idle_pct = 73;
    recv_idle_pct = 20;
    test_random_traffic(580, 50, SEQ_ALL_ONES, lowest_mark() + 64'd500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(580, 15, lowest_mark() + 64'd2000, {$urandom, $urandom});
    test_backpressure();

    in_tvalid <= 1'b0;
    while (expected_cuts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
